// ===== hdl/rmet_pkg.sv =====
// ============================================================================
// rmet_pkg
// Shared widths, codes and control and status structs for the range tracker.
// ============================================================================
package rmet_pkg;

    localparam int DISTANCE_BITS = 24;
    localparam int TALLY_BITS    = 32;

    // fixed port widths
    localparam int RAW_BITS   = 24;
    localparam int TOTAL_BITS = 33;
    localparam int QUAL_BITS  = 7;
    localparam int EXT_BITS   = 32;

    localparam int PCT_SCALE = 100;
    localparam int REM_BITS  = TALLY_BITS + QUAL_BITS;
    localparam int STEP_BITS = $clog2(QUAL_BITS);

    localparam logic OP_SUCCESS = 1'b0;
    localparam logic OP_FAIL    = 1'b1;

    typedef struct packed {
        logic wr;
        logic prefilt;
        logic ema;
    } filt_ctl_t;

    typedef struct packed {
        logic [DISTANCE_BITS-1:0] smoothed;
        logic                     valid;
        logic [DISTANCE_BITS-1:0] latest;
    } filt_stat_t;

endpackage

// ===== hdl/range_median3_ema_tracker.sv =====
// ============================================================================
// range_median3_ema_tracker
// Range tracker: median-of-three pre-filter, moving average and link quality.
// ============================================================================
//  channel  handshake            payload
//  in       in_valid / in_ready  operation, raw_distance
//  out      out_valid/out_ready  filtered_distance, distance_valid,
//                                last_raw_distance, total_count, quality_percent
//
//  a success beat steps through pre-filter, smoothing, divider start, the seven-step
//  percentage divider and done; a failure skips pre-filter and smoothing
//  in_ready is high only while the sequencer is idle, so the next beat can be
//  taken in the cycle after the result is loaded
//  a finished result waits in the output register while the next beat is taken
//  reset empties the ring and clears the smoothed value and both tallies
module range_median3_ema_tracker
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              operation,
    input  logic [rmet_pkg::RAW_BITS-1:0]     raw_distance,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [rmet_pkg::RAW_BITS-1:0]     filtered_distance,
    output logic                              distance_valid,
    output logic [rmet_pkg::RAW_BITS-1:0]     last_raw_distance,
    output logic [rmet_pkg::TOTAL_BITS-1:0]   total_count,
    output logic [rmet_pkg::QUAL_BITS-1:0]    quality_percent
);

    localparam int DB = rmet_pkg::DISTANCE_BITS;
    localparam int TB = rmet_pkg::TALLY_BITS;
    localparam int XB = rmet_pkg::EXT_BITS;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FILT  = 6'b000010,
        ST_EMA   = 6'b000100,
        ST_START = 6'b001000,
        ST_DIV   = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [TB-1:0] succ_reg;
    logic [TB-1:0] fail_reg;
    logic [TB:0]   total;

    rmet_pkg::filt_ctl_t  fctl;
    rmet_pkg::filt_stat_t fstat;

    logic [XB-1:0] raw_ext;
    logic [XB-1:0] smooth_ext;
    logic [XB-1:0] latest_ext;
    logic          in_fire;
    logic          load_out;
    logic          div_done;
    logic [rmet_pkg::QUAL_BITS-1:0] div_q;

    logic                              out_valid_reg;
    logic [rmet_pkg::RAW_BITS-1:0]     fdist_reg;
    logic                              fvalid_reg;
    logic [rmet_pkg::RAW_BITS-1:0]     lraw_reg;
    logic [rmet_pkg::TOTAL_BITS-1:0]   total_reg;
    logic [rmet_pkg::QUAL_BITS-1:0]    qual_reg;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign total    = {1'b0, succ_reg} + {1'b0, fail_reg};
    assign load_out = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign raw_ext    = XB'(raw_distance);
    assign smooth_ext = XB'(fstat.smoothed);
    assign latest_ext = XB'(fstat.latest);

    always_comb
    begin
        fctl.wr      = in_fire && (operation == rmet_pkg::OP_SUCCESS);
        fctl.prefilt = (state_reg == ST_FILT);
        fctl.ema     = (state_reg == ST_EMA);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (operation == rmet_pkg::OP_SUCCESS) ? ST_FILT : ST_START;
                end
            end
            ST_FILT:  state_next = ST_EMA;
            ST_EMA:   state_next = ST_START;
            ST_START: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            succ_reg      <= '0;
            fail_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
            begin
                if (operation == rmet_pkg::OP_SUCCESS)
                begin
                    if (!(&succ_reg))
                    begin
                        succ_reg <= succ_reg + TB'(1);
                    end
                end
                else if (!(&fail_reg))
                begin
                    fail_reg <= fail_reg + TB'(1);
                end
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            fdist_reg  <= smooth_ext[rmet_pkg::RAW_BITS-1:0];
            fvalid_reg <= fstat.valid;
            lraw_reg   <= latest_ext[rmet_pkg::RAW_BITS-1:0];
            total_reg  <= rmet_pkg::TOTAL_BITS'(total);
            qual_reg   <= div_q;
        end
    end

    rmet_filter u_filter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fctl),
        .raw   (raw_ext[DB-1:0]),
        .stat  (fstat)
    );

    rmet_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_START),
        .success  (succ_reg),
        .total    (total),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid         = out_valid_reg;
    assign filtered_distance = fdist_reg;
    assign distance_valid    = fvalid_reg;
    assign last_raw_distance = lraw_reg;
    assign total_count       = total_reg;
    assign quality_percent   = qual_reg;

endmodule

// ===== hdl/rmet_filter.sv =====
// ============================================================================
// rmet_filter
// Three-entry sample ring, median/average pre-filter and smoothing register.
// ============================================================================
module rmet_filter
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  rmet_pkg::filt_ctl_t                ctl,
    input  logic [rmet_pkg::DISTANCE_BITS-1:0] raw,
    output rmet_pkg::filt_stat_t               stat
);

    localparam int DB = rmet_pkg::DISTANCE_BITS;

    logic [DB-1:0] window_reg [3];
    logic [1:0]    pos_reg;
    logic [1:0]    count_reg;
    logic [DB-1:0] smoothed_reg;
    logic [DB-1:0] smoothed_next;
    logic          valid_reg;
    logic [DB-1:0] latest_reg;
    logic [DB-1:0] fin_reg;
    logic [DB-1:0] fin_next;

    logic [DB:0]   pair_sum;
    logic [DB-1:0] lo;
    logic [DB-1:0] hi;
    logic [DB-1:0] med;
    logic [DB+2:0] ema_sum;

    always_comb
    begin
        pair_sum = {1'b0, window_reg[0]} + {1'b0, window_reg[1]};
        if (window_reg[0] < window_reg[1])
        begin
            lo = window_reg[0];
            hi = window_reg[1];
        end
        else
        begin
            lo = window_reg[1];
            hi = window_reg[0];
        end
        if (window_reg[2] <= lo)
        begin
            med = lo;
        end
        else if (window_reg[2] >= hi)
        begin
            med = hi;
        end
        else
        begin
            med = window_reg[2];
        end
        case (count_reg)
            2'd1:    fin_next = window_reg[0];
            2'd2:    fin_next = pair_sum[DB:1];
            2'd3:    fin_next = med;
            default: fin_next = '0;
        endcase
    end

    // (3*old + new + 2) / 4
    always_comb
    begin
        ema_sum = {3'b000, smoothed_reg} + {2'b00, smoothed_reg, 1'b0}
                  + {3'b000, fin_reg} + (DB+3)'(2);
        smoothed_next = valid_reg ? ema_sum[DB+1:2] : fin_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            count_reg    <= '0;
            smoothed_reg <= '0;
            valid_reg    <= 1'b0;
            latest_reg   <= '0;
        end
        else
        begin
            if (ctl.wr)
            begin
                latest_reg <= raw;
                pos_reg    <= (pos_reg == 2'd2) ? 2'd0 : pos_reg + 2'd1;
                if (count_reg != 2'd3)
                begin
                    count_reg <= count_reg + 2'd1;
                end
            end
            if (ctl.ema)
            begin
                smoothed_reg <= smoothed_next;
                valid_reg    <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr)
        begin
            case (pos_reg)
                2'd0:    window_reg[0] <= raw;
                2'd1:    window_reg[1] <= raw;
                default: window_reg[2] <= raw;
            endcase
        end
        if (ctl.prefilt)
        begin
            fin_reg <= fin_next;
        end
    end

    assign stat.smoothed = smoothed_reg;
    assign stat.valid    = valid_reg;
    assign stat.latest   = latest_reg;

endmodule

// ===== hdl/rmet_div.sv =====
// ============================================================================
// rmet_div
// Success percentage: one multiply by 100, then one restoring step per cycle.
// ============================================================================
module rmet_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [rmet_pkg::TALLY_BITS-1:0]     success,
    input  logic [rmet_pkg::TALLY_BITS:0]       total,
    output logic                                done,
    output logic [rmet_pkg::QUAL_BITS-1:0]      quotient
);

    localparam int RB = rmet_pkg::REM_BITS;
    localparam int QB = rmet_pkg::QUAL_BITS;
    localparam int SB = rmet_pkg::STEP_BITS;

    logic [RB-1:0] rem_reg;
    logic [RB-1:0] dsh_reg;
    logic [QB-1:0] q_reg;
    logic [SB-1:0] step_reg;
    logic          run_reg;
    logic          done_reg;
    logic          zero_reg;
    logic          fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= run_reg && (step_reg == '0);
            if (start)
            begin
                run_reg  <= 1'b1;
                step_reg <= SB'(QB - 1);
            end
            else if (run_reg)
            begin
                if (step_reg == '0)
                begin
                    run_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - SB'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= RB'(success) * RB'(rmet_pkg::PCT_SCALE);
            dsh_reg  <= RB'(total) << (QB - 1);
            zero_reg <= (total == '0);
            q_reg    <= '0;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QB-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? '0 : q_reg;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Checks the range tracker beat by beat against an in-bench filter predictor:
// directed edge cases, then random success/failure runs with bursty idling on
// both channels and one long output stall.
// ============================================================================
module testbench;

    import rmet_pkg::*;

    localparam int RANDOM_ITEMS = 1280;
    localparam int QUIET_TAIL   = 150;
    localparam int LONG_HOLD    = 250;
    localparam int HOLD_AFTER   = 120;

    typedef struct {
        logic                op;
        logic [RAW_BITS-1:0] mm;
    } range_beat_t;

    typedef struct {
        logic [RAW_BITS-1:0]   smooth_mm;
        logic                  smooth_ok;
        logic [RAW_BITS-1:0]   last_mm;
        logic [TOTAL_BITS-1:0] attempts;
        logic [QUAL_BITS-1:0]  pct;
    } track_status_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  operation = OP_SUCCESS;
    logic [RAW_BITS-1:0]   raw_distance = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [RAW_BITS-1:0]   filtered_distance;
    logic                  distance_valid;
    logic [RAW_BITS-1:0]   last_raw_distance;
    logic [TOTAL_BITS-1:0] total_count;
    logic [QUAL_BITS-1:0]  quality_percent;

    range_median3_ema_tracker DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .raw_distance      (raw_distance),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .filtered_distance (filtered_distance),
        .distance_valid    (distance_valid),
        .last_raw_distance (last_raw_distance),
        .total_count       (total_count),
        .quality_percent   (quality_percent)
    );

    range_beat_t   pending_beats[$];
    track_status_t expected_status[$];
    int            fail_count = 0;

    // predictor state
    logic [DISTANCE_BITS-1:0] ring_mm [3];
    int unsigned              ring_pos = 0;
    int unsigned              ring_fill = 0;
    logic [DISTANCE_BITS-1:0] ema_mm = '0;
    logic                     ema_ok = 1'b0;
    logic [TALLY_BITS-1:0]    hits = '0;
    logic [TALLY_BITS-1:0]    misses = '0;
    logic [DISTANCE_BITS-1:0] last_mm = '0;

    initial
    begin
        ring_mm[0] = '0;
        ring_mm[1] = '0;
        ring_mm[2] = '0;
    end

    function automatic logic [DISTANCE_BITS-1:0] median_of_ring();
        logic [DISTANCE_BITS-1:0] a;
        logic [DISTANCE_BITS-1:0] b;
        logic [DISTANCE_BITS-1:0] c;
        logic [DISTANCE_BITS-1:0] t;
        a = ring_mm[0];
        b = ring_mm[1];
        c = ring_mm[2];
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        if (b > c)
        begin
            t = b;
            b = c;
            c = t;
        end
        if (a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        return b;
    endfunction

    function automatic track_status_t track_range(logic op, logic [RAW_BITS-1:0] raw_mm);
        track_status_t            st;
        logic [DISTANCE_BITS-1:0] pre;
        logic [DISTANCE_BITS+7:0] acc;
        logic [63:0]              sum;
        logic [63:0]              ratio;
        if (op == OP_SUCCESS)
        begin
            last_mm = raw_mm[DISTANCE_BITS-1:0];
            ring_mm[ring_pos] = raw_mm[DISTANCE_BITS-1:0];
            ring_pos = (ring_pos == 2) ? 0 : ring_pos + 1;
            if (ring_fill < 3)
                ring_fill++;
            if (ring_fill == 1)
                pre = ring_mm[0];
            else if (ring_fill == 2)
                pre = DISTANCE_BITS'(({8'd0, ring_mm[0]} + {8'd0, ring_mm[1]}) >> 1);
            else
                pre = median_of_ring();
            if (!ema_ok)
            begin
                ema_mm = pre;
                ema_ok = 1'b1;
            end
            else
            begin
                acc = {8'd0, ema_mm} * 3 + {8'd0, pre} + 2;
                ema_mm = DISTANCE_BITS'(acc >> 2);
            end
            if (hits != '1)
                hits++;
        end
        else
        begin
            if (misses != '1)
                misses++;
        end
        sum = 64'(hits) + 64'(misses);
        ratio = (sum == 0) ? 64'd0 : (64'(hits) * PCT_SCALE) / sum;
        st.smooth_mm = RAW_BITS'(ema_mm);
        st.smooth_ok = ema_ok;
        st.last_mm   = RAW_BITS'(last_mm);
        st.attempts  = TOTAL_BITS'(sum);
        st.pct       = QUAL_BITS'(ratio);
        return st;
    endfunction

    initial
    begin
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // input side: predict on each accepted beat, then offer the next one
    int send_gap = 0;

    always @(posedge clk)
    begin : drive_proc
        range_beat_t   beat;
        track_status_t st;
        logic          took;
        if (rst_n)
        begin
            took = in_valid && in_ready;
            if (took)
            begin
                st = track_range(operation, raw_distance);
                expected_status.push_back(st);
            end
            if (!in_valid || took)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_beats.size() > 0)
                begin
                    beat = pending_beats.pop_front();
                    operation    <= beat.op;
                    raw_distance <= beat.mm;
                    in_valid     <= 1'b1;
                    if (pending_beats.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 12);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output side: compare each result beat, random stalls, one long hold-off
    int  recv_gap = 0;
    int  hold_left = 0;
    bit  held_once = 0;
    int  results_seen = 0;

    always @(posedge clk)
    begin : watch_proc
        track_status_t st;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_status.size() == 0)
                begin
                    $error("result beat with no prediction pending");
                    fail_count++;
                end
                else
                begin
                    st = expected_status.pop_front();
                    if (filtered_distance !== st.smooth_mm)
                    begin
                        $error("filtered_distance: expected %0d, actual %0d",
                               st.smooth_mm, filtered_distance);
                        fail_count++;
                    end
                    if (distance_valid !== st.smooth_ok)
                    begin
                        $error("distance_valid: expected %0d, actual %0d",
                               st.smooth_ok, distance_valid);
                        fail_count++;
                    end
                    if (last_raw_distance !== st.last_mm)
                    begin
                        $error("last_raw_distance: expected %0d, actual %0d",
                               st.last_mm, last_raw_distance);
                        fail_count++;
                    end
                    if (total_count !== st.attempts)
                    begin
                        $error("total_count: expected %0d, actual %0d",
                               st.attempts, total_count);
                        fail_count++;
                    end
                    if (quality_percent !== st.pct)
                    begin
                        $error("quality_percent: expected %0d, actual %0d",
                               st.pct, quality_percent);
                        fail_count++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (!held_once && results_seen >= HOLD_AFTER)
            begin
                // long back-pressure so the input side backs up
                held_once = 1;
                hold_left = LONG_HOLD - 1;
                out_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if (pending_beats.size() >= QUIET_TAIL && $urandom_range(0, 9) == 0)
            begin
                recv_gap = $urandom_range(1, 12) - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_beat(logic op, logic [RAW_BITS-1:0] raw_mm);
        range_beat_t b;
        b.op = op;
        b.mm = raw_mm;
        pending_beats.push_back(b);
    endtask

    initial
    begin
        int          miss_odds;
        int          style;
        int unsigned base;
        logic        op;
        logic [RAW_BITS-1:0] sample_mm;

        // failure before any success, then extremes and median orderings
        queue_beat(OP_FAIL, 24'h123456);
        queue_beat(OP_SUCCESS, 24'h000000);
        queue_beat(OP_SUCCESS, 24'hFFFFFF);
        queue_beat(OP_SUCCESS, 24'hFFFFFF);
        queue_beat(OP_SUCCESS, 24'hAAAAAA);
        queue_beat(OP_SUCCESS, 24'h555555);
        queue_beat(OP_FAIL, 24'hFFFFFF);
        queue_beat(OP_FAIL, 24'h000000);
        queue_beat(OP_SUCCESS, 24'd1);
        queue_beat(OP_SUCCESS, 24'd2);
        queue_beat(OP_SUCCESS, 24'd3);
        queue_beat(OP_SUCCESS, 24'd3);
        queue_beat(OP_SUCCESS, 24'd2);
        queue_beat(OP_SUCCESS, 24'd1);
        queue_beat(OP_SUCCESS, 24'd500);
        queue_beat(OP_SUCCESS, 24'd100);
        queue_beat(OP_SUCCESS, 24'd900);
        queue_beat(OP_FAIL, 24'd0);
        queue_beat(OP_SUCCESS, 24'hFFFFFE);
        queue_beat(OP_SUCCESS, 24'hFFFFFD);
        queue_beat(OP_SUCCESS, 24'hFFFFFF);
        queue_beat(OP_SUCCESS, 24'hFFFFFF);

        // random runs of 20 beats, each with its own failure mix and range style
        miss_odds = 0;
        style = 0;
        base = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 20 == 0)
            begin
                miss_odds = $urandom_range(0, 8);
                style = $urandom_range(0, 3);
                base = $urandom_range(0, 24'hFFFFFF);
            end
            op = ($urandom_range(1, 8) <= miss_odds) ? OP_FAIL : OP_SUCCESS;
            case (style)
                0: sample_mm = RAW_BITS'($urandom);
                1: sample_mm = RAW_BITS'(base + $urandom_range(0, 255));
                2: sample_mm = 24'hFFFFFF - RAW_BITS'($urandom_range(0, 1023));
                default: sample_mm = RAW_BITS'($urandom_range(0, 5000));
            endcase
            queue_beat(op, sample_mm);
        end

        @(posedge rst_n);
        @(negedge clk);
        while (pending_beats.size() > 0 || in_valid || expected_status.size() > 0)
            @(negedge clk);
        repeat (30) @(negedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
